// File: sv/sser_pkg.sv
// Shared constants and types for the sensor scan edge recorder.
// No dependencies; every other file of the block imports this package.
package sser_pkg;

    localparam int SCAN_BYTES_DEF   = 10;
    localparam int RECENT_DEPTH_DEF = 10;

    localparam int BYTE_W    = 8;
    localparam int SENSOR_W  = 7;
    localparam int MODULE_W  = 3;
    localparam int CONTACT_W = 5;
    localparam int SLOT_W    = 4;
    localparam int BIT_IDX_W = 3;
    localparam int MODULE_SIZE = 16;

    localparam int RES_W   = SENSOR_W + MODULE_W + CONTACT_W + SLOT_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic                valid;
        logic [SENSOR_W-1:0] number;
    } t_ring_push;

    typedef struct packed {
        logic [SLOT_W-1:0]    ring_slot;
        logic [CONTACT_W-1:0] contact_number;
        logic [MODULE_W-1:0]  module_index;
        logic [SENSOR_W-1:0]  sensor_number;
    } t_result;

    // Highest set bit of a byte.
    function automatic logic [BIT_IDX_W-1:0] top_bit(input logic [BYTE_W-1:0] bits);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (bits[k]) begin
                idx = BIT_IDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// File: sv/sensor_scan_edge_recorder.sv
// Top level: byte intake, rising-bit emitter and result register.
// Depends on sser_pkg, sser_prev_store and sser_ring.
//
// channel | dir | handshake           | payload
// s       | in  | i_s_tvalid/o_s_tready | tdata[7:0] scan_byte
// m       | out | o_m_tvalid/i_m_tready | tdata: sensor, module, contact, slot; tlast
//
// One result per cycle while the output is not stalled; a byte with k rising bits
// holds the emitter for k results, a byte with none gives no result. Results pass
// the stage-1, emitter and output registers. The emitter and the single-port
// previous-byte memory set the rate. Synchronous reset clears the valid bits of the
// memory at once. A stalled output holds its word while the next byte is fetched.
module sensor_scan_edge_recorder #(
    parameter int SCAN_BYTES   = sser_pkg::SCAN_BYTES_DEF,
    parameter int RECENT_DEPTH = sser_pkg::RECENT_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [sser_pkg::BYTE_W-1:0]   i_s_tdata,   // [7:0] scan_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [6:0] sensor_number, [9:7] module_index, [14:10] contact_number,
    // [18:15] ring_slot, [23:19] zero
    output logic [sser_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast    // last_of_byte
);
    import sser_pkg::*;

    localparam int POS_W = $clog2(SCAN_BYTES);
    localparam int NUM_W = POS_W + BIT_IDX_W;

    logic              s_acc;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [BYTE_W-1:0] prev;
    logic [POS_W-1:0]  s1_pos;
    logic [BYTE_W-1:0] rising;
    logic              s1_adv;

    logic              r_em_valid;
    logic [BYTE_W-1:0] r_em_bits;
    logic [POS_W-1:0]  r_em_pos;
    logic [BIT_IDX_W-1:0] em_idx;
    logic [BYTE_W-1:0] em_rest;
    logic              em_last;
    logic              em_fire;
    logic              em_free;
    logic              out_free;

    logic [NUM_W+SENSOR_W-1:0] num_ext;
    logic [SENSOR_W-1:0]       num;
    logic [SLOT_W-1:0]         slot;
    t_ring_push                push;

    logic    r_out_valid;
    t_result r_out;
    logic    r_out_last;

    assign out_free   = !r_out_valid || i_m_tready;
    assign em_fire    = r_em_valid && out_free;
    assign em_idx     = top_bit(r_em_bits);
    assign em_rest    = r_em_bits & ~(BYTE_W'(1) << em_idx);
    assign em_last    = (em_rest == '0);
    assign em_free    = !r_em_valid || (em_fire && em_last);
    assign s1_adv     = r_s1_valid && em_free;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign rising     = r_s1_byte & ~prev;

    sser_prev_store #(.SCAN_BYTES(SCAN_BYTES)) u_prev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (s_acc),
        .i_byte  (i_s_tdata),
        .o_prev  (prev),
        .o_pos   (s1_pos)
    );

    // 16*(pos/2) + (odd ? 0 : 8) + bit, i.e. {pos ^ 1, bit}
    assign num_ext = {{SENSOR_W{1'b0}}, r_em_pos ^ POS_W'(1), em_idx};
    assign num     = num_ext[SENSOR_W-1:0];

    assign push.valid  = em_fire;
    assign push.number = num;

    sser_ring #(.RECENT_DEPTH(RECENT_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_slot  (slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
        end else begin
            priority if (s1_adv && rising != '0) begin
                r_em_valid <= 1'b1;
                r_em_bits  <= rising;
                r_em_pos   <= s1_pos;
            end else if (em_fire) begin
                r_em_valid <= !em_last;
                r_em_bits  <= em_rest;
            end else begin
                r_em_valid <= r_em_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= em_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            r_out.sensor_number  <= num;
            r_out.module_index   <= num[SENSOR_W-1:4];
            r_out.contact_number <= CONTACT_W'(MODULE_SIZE) - {1'b0, num[3:0]};
            r_out.ring_slot      <= slot;
            r_out_last           <= em_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(r_out);
    assign o_m_tlast  = r_out_last;

endmodule

// File: sv/sser_prev_store.sv
// Previous-byte memory with the scan position counter.
// Depends on sser_pkg.
module sser_prev_store #(
    parameter int SCAN_BYTES = sser_pkg::SCAN_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [sser_pkg::BYTE_W-1:0] i_byte,
    output logic [sser_pkg::BYTE_W-1:0] o_prev,
    output logic [$clog2(SCAN_BYTES)-1:0] o_pos
);
    import sser_pkg::*;

    localparam int POS_W = $clog2(SCAN_BYTES);

    logic [BYTE_W-1:0]     r_mem [SCAN_BYTES];
    logic [SCAN_BYTES-1:0] r_vld;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic [POS_W-1:0]      r_rd_pos;
    logic [BYTE_W-1:0]     r_rd_data;
    logic                  r_rd_ok;

    assign n_pos = (r_pos == POS_W'(SCAN_BYTES - 1)) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vld <= '0;
        end else if (i_wr) begin
            r_pos        <= n_pos;
            r_vld[r_pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_rd_data    <= r_mem[r_pos];
            r_rd_ok      <= r_vld[r_pos];
            r_rd_pos     <= r_pos;
            r_mem[r_pos] <= i_byte;
        end
    end

    assign o_prev = r_rd_ok ? r_rd_data : '0;
    assign o_pos  = r_rd_pos;

endmodule

// File: sv/sser_ring.sv
// Ring of recent sensor numbers with its write slot and fill flag.
// Depends on sser_pkg.
module sser_ring #(
    parameter int RECENT_DEPTH = sser_pkg::RECENT_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sser_pkg::t_ring_push        i_push,
    output logic [sser_pkg::SLOT_W-1:0] o_slot
);
    import sser_pkg::*;

    localparam int RS_W = $clog2(RECENT_DEPTH);

    logic [SENSOR_W-1:0] r_mem [RECENT_DEPTH];
    logic [RS_W-1:0]     r_ws;
    logic [RS_W-1:0]     n_ws;
    logic                r_filled;
    logic [RS_W+SLOT_W-1:0] slot_ext;

    assign n_ws     = (r_ws == RS_W'(RECENT_DEPTH - 1)) ? '0 : r_ws + 1'b1;
    assign slot_ext = {{SLOT_W{1'b0}}, n_ws};
    assign o_slot   = slot_ext[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws     <= '0;
            r_filled <= 1'b0;
        end else if (i_push.valid) begin
            r_ws <= n_ws;
            if (n_ws == RS_W'(RECENT_DEPTH - 1)) begin
                r_filled <= 1'b1;
            end
        end
    end

    // Slot 0 is written only after the ring has filled.
    always_ff @(posedge i_clk) begin
        if (i_push.valid && (r_filled || n_ws != '0)) begin
            r_mem[n_ws] <= i_push.number;
        end
    end

endmodule

// File: sv/sser_check.sv
// Port-level checks for the sensor scan edge recorder, bound to the top level.
// Depends on sser_pkg and sensor_scan_edge_recorder.
module sser_check #(
    parameter int RECENT_DEPTH = sser_pkg::RECENT_DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [sser_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                          o_m_tlast
);
    import sser_pkg::*;

    t_result res;
    assign res = o_m_tdata[RES_W-1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    a_module: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> res.module_index == res.sensor_number[SENSOR_W-1:4])
        else $error("module index does not match sensor number");

    a_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            res.contact_number == CONTACT_W'(MODULE_SIZE) - {1'b0, res.sensor_number[3:0]})
        else $error("contact number does not match sensor number");

    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (RECENT_DEPTH > 16) || (int'(res.ring_slot) < RECENT_DEPTH))
        else $error("ring slot out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind sensor_scan_edge_recorder sser_check #(.RECENT_DEPTH(RECENT_DEPTH)) u_sser_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// File: verif/tb_sensor_scan_edge_recorder.sv
// Self-checking testbench for sensor_scan_edge_recorder: drives scan bytes on the
// slave stream and checks every edge word on the master stream against a predictor.
// Depends on sser_pkg and the sensor_scan_edge_recorder RTL.
module tb_sensor_scan_edge_recorder;
    import sser_pkg::*;

    localparam int SCAN_LEN    = SCAN_BYTES_DEF;
    localparam int RING_LEN    = RECENT_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        t_result word;
        logic    last;
    } t_edge_hit;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [BYTE_W-1:0]   i_s_tdata  = '0;   // [7:0] scan_byte
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [6:0] sensor_number, [9:7] module_index, [14:10] contact_number,
    // [18:15] ring_slot, [23:19] zero
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tlast;        // last_of_byte

    logic [BYTE_W-1:0] prev_scan [SCAN_LEN];
    int                scan_pos      = 0;
    int                ring_wr       = 0;
    t_edge_hit         expected_edges [$];
    bit                idle_on       = 1'b1;
    int                ready_hold    = 0;
    int                mismatch_count = 0;
    int                bytes_sent    = 0;
    int                edges_checked = 0;
    int                cycle_count   = 0;

    sensor_scan_edge_recorder #(
        .SCAN_BYTES   (SCAN_LEN),
        .RECENT_DEPTH (RING_LEN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        for (int p = 0; p < SCAN_LEN; p++) begin
            prev_scan[p] = '0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_edges.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 6);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic predict_edges(input logic [BYTE_W-1:0] scan_byte);
        logic [BYTE_W-1:0] rising;
        t_edge_hit         hit;
        int                lowest;
        int                num;
        rising = scan_byte & ~prev_scan[scan_pos];
        lowest = -1;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (rising[b]) begin
                lowest = b;
            end
        end
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (rising[b]) begin
                num = ((scan_pos % 2) != 0 ? 0 : 8) + b + MODULE_SIZE * (scan_pos / 2);
                hit.word.sensor_number  = SENSOR_W'(num);
                hit.word.module_index   = MODULE_W'(hit.word.sensor_number / MODULE_SIZE);
                hit.word.contact_number =
                    CONTACT_W'(MODULE_SIZE - hit.word.sensor_number % MODULE_SIZE);
                ring_wr                 = (ring_wr + 1) % RING_LEN;
                hit.word.ring_slot      = SLOT_W'(ring_wr);
                hit.last                = (b == lowest);
                expected_edges.push_back(hit);
            end
        end
        prev_scan[scan_pos] = scan_byte;
        scan_pos            = (scan_pos + 1) % SCAN_LEN;
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0d, got %0d (edge word %0d)",
                     what, want, got, edges_checked);
        end
    endtask

    always @(posedge i_clk) begin
        t_result   got;
        t_edge_hit want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[RES_W-1:0]);
            if (expected_edges.size() == 0) begin
                report_mismatch("unexpected word", 0, o_m_tdata);
            end else begin
                want = expected_edges.pop_front();
                if (got.sensor_number !== want.word.sensor_number)
                    report_mismatch("sensor_number", want.word.sensor_number,
                                    got.sensor_number);
                if (got.module_index !== want.word.module_index)
                    report_mismatch("module_index", want.word.module_index,
                                    got.module_index);
                if (got.contact_number !== want.word.contact_number)
                    report_mismatch("contact_number", want.word.contact_number,
                                    got.contact_number);
                if (got.ring_slot !== want.word.ring_slot)
                    report_mismatch("ring_slot", want.word.ring_slot, got.ring_slot);
                if (o_m_tlast !== want.last)
                    report_mismatch("tlast", want.last, o_m_tlast);
                if ((o_m_tdata >> RES_W) !== '0)
                    report_mismatch("tdata padding", 0, o_m_tdata >> RES_W);
            end
            edges_checked++;
        end
    end

    task automatic send_scan_byte(input logic [BYTE_W-1:0] scan_byte);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= scan_byte;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        predict_edges(scan_byte);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_edges.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [BYTE_W-1:0] rand_scan_byte();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // full scan of 0xFF, repeat without edges, clear, then sparse patterns
    task automatic test_directed_scan();
        logic [BYTE_W-1:0] pattern [4];
        pattern = '{8'h01, 8'h80, 8'hAA, 8'h55};
        for (int p = 0; p < SCAN_LEN; p++) send_scan_byte(8'hFF);
        send_scan_byte(8'hFF);
        for (int p = 1; p < SCAN_LEN - 1; p++) send_scan_byte(8'h00);
        send_scan_byte(8'hFF);
        send_scan_byte(8'h00);
        for (int k = 0; k < 4; k++) send_scan_byte(pattern[k]);
    endtask

    task automatic test_random_scan(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 20) idle_on = 1'b0;
            if (k % 40 == 35) idle_on = 1'b1;
            send_scan_byte(rand_scan_byte());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause(input int count);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < count; k++) send_scan_byte(rand_scan_byte());
            wait_drained();
            @(posedge i_clk);
        end
    endtask

    task automatic test_back_to_back_tail(input int count);
        idle_on = 1'b0;
        for (int k = 0; k < count; k++) send_scan_byte(rand_scan_byte());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_scan();
        test_random_scan(160);
        test_drain_pause(20);
        test_back_to_back_tail(60);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d scan bytes over %0d scan passes, %0d edge words checked",
                 bytes_sent, bytes_sent / SCAN_LEN, edges_checked);
        $display("with random stalls on both streams, %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && expected_edges.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/sser_pkg.sv
sv/sser_prev_store.sv
sv/sser_ring.sv
sv/sensor_scan_edge_recorder.sv
sv/sser_check.sv
verif/tb_sensor_scan_edge_recorder.sv
